[hw/rtl/mbps_pkg.sv]
// Shared constants and types for the masked byte pattern search block.
// Used by mbps_regs and masked_byte_pattern_search; no dependencies.
`timescale 1ns / 1ps

package mbps_pkg;

  localparam int MAX_PATTERN_DEF = 32;
  localparam int ADDR_BITS_DEF   = 32;

  localparam int PAT_BYTES  = 32;
  localparam int PAT_IDX_W  = 5;
  localparam int LEN_W      = 6;
  localparam int CFG_ADDR_W = 6;
  localparam int CFG_DATA_W = 64;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_PAT_LO     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PAT_MID_LO = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_PAT_MID_HI = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_PAT_HI     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_CARE_MASK  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_PAT_LEN    = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_BASE_ADDR  = 3'd6;

  // Scan settings derived from the configuration registers.
  typedef struct packed {
    logic [31:0]      addr_bias;  // base_address minus effective length
    logic [LEN_W-1:0] len;        // effective pattern length, 1..MAX_PATTERN
  } scan_cfg_t;

endpackage

[hw/rtl/mbps_cell.sv]
// One window cell: holds one image byte, passes it to the next cell on each
// accepted item and compares it with its pattern byte. No dependencies.
`timescale 1ns / 1ps

module mbps_cell (
  input  logic       clk,
  input  logic       shift_en,
  input  logic [7:0] byte_in,
  input  logic [7:0] ref_byte,
  input  logic       care_en,
  output logic [7:0] byte_out,
  output logic       hit
);

  logic [7:0] byte_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_r <= byte_in;
    end
  end

  assign byte_out = byte_r;
  assign hit      = !care_en || (byte_r == ref_byte);

endmodule

[hw/rtl/mbps_regs.sv]
// Configuration register file with APB-style access, plus the per-cell
// pattern bytes and care bits aligned to the window. Depends on mbps_pkg.
`timescale 1ns / 1ps

module mbps_regs #(
  parameter int MAX_PATTERN = mbps_pkg::MAX_PATTERN_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mbps_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [mbps_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [mbps_pkg::CFG_DATA_W-1:0] prdata,
  output logic [MAX_PATTERN-1:0][7:0]     ref_bytes,
  output logic [MAX_PATTERN-1:0]          ref_care,
  output mbps_pkg::scan_cfg_t             scan_cfg
);

  import mbps_pkg::*;

  logic [63:0]              pat_r [4];
  logic [31:0]              care_r;
  logic [LEN_W-1:0]         len_r;
  logic [31:0]              base_r;
  logic [REG_IDX_W-1:0]     reg_idx;
  logic                     wr_en;
  logic [8*PAT_BYTES-1:0]   pat_vec;
  logic [LEN_W-1:0]         len_eff;
  logic [MAX_PATTERN-1:0][7:0] ref_bytes_nxt;
  logic [MAX_PATTERN-1:0]   ref_care_nxt;
  logic [MAX_PATTERN-1:0][7:0] ref_bytes_r;
  logic [MAX_PATTERN-1:0]   ref_care_r;
  scan_cfg_t                scan_cfg_r;

  assign reg_idx = paddr[CFG_ADDR_W-1:3];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r[0] <= '0;
      pat_r[1] <= '0;
      pat_r[2] <= '0;
      pat_r[3] <= '0;
      care_r   <= '1;
      len_r    <= LEN_W'(1);
      base_r   <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_PAT_LO:     pat_r[0] <= pwdata;
        REG_PAT_MID_LO: pat_r[1] <= pwdata;
        REG_PAT_MID_HI: pat_r[2] <= pwdata;
        REG_PAT_HI:     pat_r[3] <= pwdata;
        REG_CARE_MASK:  care_r   <= pwdata[31:0];
        REG_PAT_LEN:    len_r    <= pwdata[LEN_W-1:0];
        REG_BASE_ADDR:  base_r   <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PAT_LO:     prdata = pat_r[0];
      REG_PAT_MID_LO: prdata = pat_r[1];
      REG_PAT_MID_HI: prdata = pat_r[2];
      REG_PAT_HI:     prdata = pat_r[3];
      REG_CARE_MASK:  prdata = {32'd0, care_r};
      REG_PAT_LEN:    prdata = {{(CFG_DATA_W-LEN_W){1'b0}}, len_r};
      REG_BASE_ADDR:  prdata = {32'd0, base_r};
      default:        prdata = '0;
    endcase
  end

  assign pat_vec = {pat_r[3], pat_r[2], pat_r[1], pat_r[0]};

  // Clamp the length: zero acts as one, anything above the window as full.
  always_comb begin
    if (len_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (len_r > LEN_W'(MAX_PATTERN)) begin
      len_eff = LEN_W'(MAX_PATTERN);
    end else begin
      len_eff = len_r;
    end
  end

  // Cell k holds the byte k items old; it lines up with pattern byte len-1-k.
  always_comb begin
    logic [LEN_W-1:0] idx;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      idx = len_eff - LEN_W'(k) - LEN_W'(1);
      ref_bytes_nxt[k] = pat_vec[8*idx[PAT_IDX_W-1:0] +: 8];
      ref_care_nxt[k]  = (LEN_W'(k) < len_eff) && care_r[idx[PAT_IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    ref_bytes_r          <= ref_bytes_nxt;
    ref_care_r           <= ref_care_nxt;
    scan_cfg_r.len       <= len_eff;
    scan_cfg_r.addr_bias <= base_r - {{(32-LEN_W){1'b0}}, len_eff};
  end

  assign ref_bytes = ref_bytes_r;
  assign ref_care  = ref_care_r;
  assign scan_cfg  = scan_cfg_r;

endmodule

[hw/rtl/masked_byte_pattern_search.sv]
// Masked byte pattern search: scans a memory image one byte per item and
// reports the first place where a pattern of up to MAX_PATTERN bytes, each
// with a care bit, matches. It takes one byte every cycle while no result waits
// on a stalled output; each byte is registered into the row of window cells, the
// AND over their compare bits decides, and the result is registered on the output
// register. An image gives one result: found with base_address plus the match
// offset, or not found on the byte marked last. Leave one clock between the last
// configuration write and the first byte of a scan. Depends on mbps_pkg,
// mbps_regs and mbps_cell.
`timescale 1ns / 1ps

module masked_byte_pattern_search #(
  parameter int MAX_PATTERN = mbps_pkg::MAX_PATTERN_DEF,
  parameter int ADDR_BITS   = mbps_pkg::ADDR_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mbps_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [mbps_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [mbps_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      in_data_byte,
  input  logic                            in_last_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_found,
  output logic [31:0]                     out_match_address
);

  import mbps_pkg::*;

  localparam logic [31:0] ADDR_MASK =
    (ADDR_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << ADDR_BITS) - 64'd1);

  logic [MAX_PATTERN-1:0][7:0] ref_bytes;
  logic [MAX_PATTERN-1:0]      ref_care;
  scan_cfg_t                   scan_cfg;

  logic [7:0]             win [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] hit;

  logic        advance;
  logic        accept;
  logic        s1_valid_r;
  logic        s1_last_r;
  logic        restart_r;
  logic [31:0] bytes_seen_r;
  logic [31:0] bytes_seen_nxt;
  logic        scan_done_r;
  logic        match;
  logic        emit;
  logic [31:0] addr_sum;
  logic        out_valid_r;
  logic        out_found_r;
  logic [31:0] out_addr_r;

  mbps_regs #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .ref_bytes(ref_bytes),
    .ref_care (ref_care),
    .scan_cfg (scan_cfg)
  );

  assign pready = 1'b1;

  // Hold everything while a result waits on a stalled output.
  assign advance  = !(out_valid_r && out_stall);
  assign in_stall = !advance;
  assign accept   = in_valid && advance;

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    logic [7:0] byte_in;
    if (k == 0) begin : g_head
      assign byte_in = in_data_byte;
    end else begin : g_link
      assign byte_in = win[k-1];
    end
    mbps_cell u_cell (
      .clk     (clk),
      .shift_en(accept),
      .byte_in (byte_in),
      .ref_byte(ref_bytes[k]),
      .care_en (ref_care[k]),
      .byte_out(win[k]),
      .hit     (hit[k])
    );
  end

  // A new image restarts the count; otherwise count up and saturate.
  always_comb begin
    if (restart_r) begin
      bytes_seen_nxt = 32'd1;
    end else if (bytes_seen_r == 32'hFFFF_FFFF) begin
      bytes_seen_nxt = bytes_seen_r;
    end else begin
      bytes_seen_nxt = bytes_seen_r + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      s1_last_r    <= 1'b0;
      restart_r    <= 1'b0;
      bytes_seen_r <= '0;
    end else if (advance) begin
      s1_valid_r <= in_valid;
      if (in_valid) begin
        s1_last_r    <= in_last_byte;
        restart_r    <= in_last_byte;
        bytes_seen_r <= bytes_seen_nxt;
      end
    end
  end

  // Window bytes from an earlier image are never compared: the count gates them.
  assign match    = (&hit) && (bytes_seen_r >= {{(32-LEN_W){1'b0}}, scan_cfg.len});
  assign emit     = s1_valid_r && !scan_done_r && (match || s1_last_r);
  assign addr_sum = bytes_seen_r + scan_cfg.addr_bias;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_done_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= emit;
      if (s1_valid_r) begin
        if (s1_last_r) begin
          scan_done_r <= 1'b0;
        end else if (!scan_done_r && match) begin
          scan_done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_found_r <= match;
      out_addr_r  <= match ? (addr_sum & ADDR_MASK) : 32'd0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_found         = out_found_r;
  assign out_match_address = out_addr_r;

  a_done_comes_with_found: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(scan_done_r) |-> out_valid_r && out_found_r)
    else $error("scan marked done without a found result");

  a_quiet_after_match: assert property (@(posedge clk) disable iff (!rst_n)
    scan_done_r && advance |=> !out_valid_r)
    else $error("result emitted after the match of this image");

  a_restart_count: assert property (@(posedge clk) disable iff (!rst_n)
    accept && restart_r |=> bytes_seen_r == 32'd1)
    else $error("byte count not restarted at new image");

  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_found_r |-> out_addr_r == 32'd0)
    else $error("not-found result carries an address");

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for masked_byte_pattern_search: feeds byte images with planted
// patterns under random pacing and checks each report against a software scan.
// Depends on mbps_pkg and the masked_byte_pattern_search RTL.
`timescale 1ns / 1ps

module tb;
  import mbps_pkg::*;

  localparam int BYTE_TARGET   = 1100;
  localparam int LONG_HOLD     = 300;
  localparam int SETTLE_CYCLES = 6;
  localparam int CYCLE_LIMIT   = 400000;

  typedef enum int {PACE_STEADY, PACE_SPARSE, PACE_BURSTY} pace_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } image_byte_t;

  typedef struct packed {
    logic        found;
    logic [31:0] addr;
  } scan_report_t;

  logic                  clk   = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr   = '0;
  logic [CFG_DATA_W-1:0] pwdata  = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid     = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_data_byte = 8'h00;
  logic                  in_last_byte = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_found;
  logic [31:0]           out_match_address;

  // Shadow of the scan settings, at their reset values
  logic [63:0]      pat_word [4] = '{default: 64'h0};
  logic [31:0]      care_bits    = 32'hFFFF_FFFF;
  logic [LEN_W-1:0] pat_len      = 6'd1;
  logic [31:0]      base_addr    = 32'h0;

  // Predicted scan state
  logic [7:0]  window [PAT_BYTES] = '{default: 8'h00};
  logic [31:0] bytes_in_image = 32'h0;
  bit          matched = 1'b0;

  image_byte_t  pending_bytes [$];
  scan_report_t expected_reports [$];
  image_byte_t  tx_next;
  scan_report_t rx_want;

  pace_t       tx_pace = PACE_BURSTY;
  pace_t       rx_pace = PACE_BURSTY;
  int unsigned tx_wait = 0;
  int unsigned rx_wait = 0;
  int          long_holds_asked = 0;
  int          long_holds_done  = 0;
  int          items_queued  = 0;
  int          items_taken   = 0;
  int          bytes_scanned = 0;
  int          found_total   = 0;
  int          miss_total    = 0;
  int          error_count   = 0;
  int          cycle_count   = 0;
  int          phase_count   = 0;

  masked_byte_pattern_search u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_last_byte      (in_last_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_found         (out_found),
    .out_match_address (out_match_address)
  );

  always #2 clk = ~clk;

  function automatic logic [7:0] pat_byte(input int p);
    return pat_word[p / 8][(p % 8) * 8 +: 8];
  endfunction

  function automatic int eff_len();
    if (pat_len == 0) return 1;
    if (pat_len > PAT_BYTES) return PAT_BYTES;
    return int'(pat_len);
  endfunction

  function automatic int unsigned draw_wait(input pace_t pace);
    case (pace)
      PACE_STEADY: return 0;
      PACE_SPARSE: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 18) : 0;
      default:     return $urandom_range(0, 18);
    endcase
  endfunction

  // Shift one image byte into the window and queue the report it causes, if any.
  function automatic void advance_scan(input logic [7:0] data, input logic last);
    int           len;
    bit           hit;
    scan_report_t rep;
    if (!matched) begin
      bytes_scanned++;
      len = eff_len();
      for (int i = PAT_BYTES - 1; i > 0; i--) window[i] = window[i - 1];
      window[0] = data;
      if (bytes_in_image != 32'hFFFF_FFFF) bytes_in_image++;
      hit = (bytes_in_image >= 32'(len));
      for (int p = 0; p < len; p++)
        if (care_bits[p] && window[len - 1 - p] != pat_byte(p)) hit = 1'b0;
      if (hit) begin
        rep.found = 1'b1;
        rep.addr  = base_addr + bytes_in_image - 32'(len);
        expected_reports.insert(expected_reports.size(), rep);
        matched = 1'b1;
        found_total++;
      end else if (last) begin
        rep.found = 1'b0;
        rep.addr  = 32'h0;
        expected_reports.insert(expected_reports.size(), rep);
        miss_total++;
      end
    end
    if (last) begin
      window         = '{default: 8'h00};
      bytes_in_image = 32'h0;
      matched        = 1'b0;
    end
  endfunction

  // Byte driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_wait = 0;
    end else begin
      if (in_valid && !in_stall) begin
        advance_scan(in_data_byte, in_last_byte);
        items_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (tx_wait > 0) begin
          tx_wait--;
          in_valid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          tx_next = pending_bytes.pop_front();
          in_data_byte <= tx_next.data;
          in_last_byte <= tx_next.last;
          in_valid     <= 1'b1;
          tx_wait = draw_wait(tx_pace);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Report monitor and receiver stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          error_count++;
          $display("%0t: unexpected report, expected none, actual found=%0b address=%08h",
                   $time, out_found, out_match_address);
        end else begin
          rx_want = expected_reports.pop_front();
          if (out_found !== rx_want.found) begin
            error_count++;
            $display("%0t: found mismatch, expected %0b, actual %0b",
                     $time, rx_want.found, out_found);
          end
          if (out_match_address !== rx_want.addr) begin
            error_count++;
            $display("%0t: match_address mismatch, expected %08h, actual %08h",
                     $time, rx_want.addr, out_match_address);
          end
        end
        rx_wait = draw_wait(rx_pace);
      end
      if (long_holds_done != long_holds_asked) begin
        rx_wait += LONG_HOLD;
        long_holds_done++;
      end
      if (rx_wait > 0) begin
        rx_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d reports outstanding",
               cycle_count, expected_reports.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_PAT_LO:     pat_word[0] = value;
      REG_PAT_MID_LO: pat_word[1] = value;
      REG_PAT_MID_HI: pat_word[2] = value;
      REG_PAT_HI:     pat_word[3] = value;
      REG_CARE_MASK:  care_bits   = value[31:0];
      REG_PAT_LEN:    pat_len     = value[LEN_W-1:0];
      REG_BASE_ADDR:  base_addr   = value[31:0];
      default: ;
    endcase
  endtask

  task automatic program_scan(input logic [63:0] w0, input logic [63:0] w1,
                              input logic [63:0] w2, input logic [63:0] w3,
                              input logic [31:0] mask, input logic [LEN_W-1:0] len,
                              input logic [31:0] base);
    write_reg(REG_PAT_LO, w0);
    write_reg(REG_PAT_MID_LO, w1);
    write_reg(REG_PAT_MID_HI, w2);
    write_reg(REG_PAT_HI, w3);
    write_reg(REG_CARE_MASK, {32'h0, mask});
    write_reg(REG_PAT_LEN, {58'h0, len});
    write_reg(REG_BASE_ADDR, {32'h0, base});
    // wait before the first byte so the last write has settled
    repeat (2) @(posedge clk);
  endtask

  task automatic add_byte(input logic [7:0] data, input logic last);
    image_byte_t b;
    b.data = data;
    b.last = last;
    pending_bytes.insert(pending_bytes.size(), b);
    items_queued++;
  endtask

  // Random image of n bytes, optionally with the pattern planted (possibly cut off at the end).
  task automatic add_image(input int n, input bit plant, input bit narrow);
    logic [7:0] img [$];
    int         len;
    int         at;
    len = eff_len();
    for (int i = 0; i < n; i++)
      img.insert(img.size(),
                 (narrow && $urandom_range(0, 1)) ? pat_byte($urandom_range(0, len - 1))
                                                  : 8'($urandom));
    if (plant) begin
      if (n >= len && $urandom_range(0, 3) != 0) at = $urandom_range(0, n - len);
      else at = $urandom_range(0, n - 1);
      for (int p = 0; p < len && at + p < n; p++)
        if (care_bits[p]) img[at + p] = pat_byte(p);
    end
    for (int i = 0; i < n; i++) add_byte(img[i], i == n - 1);
  endtask

  // Hold until every byte is taken and every report is in, then let the pipeline settle.
  task automatic wait_idle();
    do @(posedge clk);
    while (items_taken != items_queued || expected_reports.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [LEN_W-1:0] len;
    logic [31:0]      mask;
    logic [31:0]      base;
    int               phase_end;
    int               n;
    bit               long_phase;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: one literal 0x00 byte
    add_byte(8'hFF, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'hFF, 1'b1);
    add_byte(8'hFF, 1'b1);
    add_byte(8'h00, 1'b1);
    wait_idle();

    // Length 0 acts as 1 and a wildcard byte 0 matches anything
    program_scan(64'hFFFF_FFFF_FFFF_FFA5, 64'h0, 64'h0, 64'h0, 32'h0, 6'd0, 32'hFFFF_FFFF);
    add_byte(8'hA5, 1'b1);
    add_byte(8'h5A, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'hFF, 1'b1);
    wait_idle();

    // Three bytes, middle one wildcard: short image, address wrap, literal byte 0
    program_scan(64'h0000_0000_0080_FF00, '1, '1, '1, 32'h5, 6'd3, 32'hFFFF_FFFE);
    add_byte(8'h00, 1'b0);
    add_byte(8'h11, 1'b1);
    add_byte(8'h7E, 1'b0);
    add_byte(8'h7E, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h42, 1'b0);
    add_byte(8'h80, 1'b1);
    add_byte(8'h01, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h80, 1'b1);
    wait_idle();

    while (items_queued < BYTE_TARGET) begin
      case (phase_count)
        0: len = 6'd32;
        1: len = 6'd63;
        3: len = 6'd0;
        4: len = 6'd33;
        default: len = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(9, 32))
                                                   : 6'($urandom_range(1, 6));
      endcase
      case ($urandom_range(0, 4))
        0: mask = 32'hFFFF_FFFF;
        1: mask = 32'h0;
        2: mask = $urandom;
        3: mask = ~(32'h1 << $urandom_range(0, 31));
        default: mask = $urandom | $urandom;
      endcase
      case ($urandom_range(0, 3))
        0: base = 32'h0;
        1: base = 32'hFFFF_FFFF;
        2: base = 32'hFFFF_FFFF - $urandom_range(0, 20);
        default: base = $urandom;
      endcase
      program_scan({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                   {$urandom, $urandom}, mask, len, base);

      tx_pace = pace_t'($urandom_range(0, 2));
      rx_pace = pace_t'($urandom_range(0, 2));
      // Long receiver hold-off while short images keep coming: fill the block up
      long_phase = (phase_count == 2 || phase_count == 7);
      if (long_phase) begin
        tx_pace = PACE_STEADY;
        long_holds_asked++;
      end

      phase_end = items_queued + 100 + $urandom_range(0, 60);
      while (items_queued < phase_end) begin
        if (long_phase) n = $urandom_range(1, 4);
        else if ($urandom_range(0, 7) == 0) n = $urandom_range(1, 64);
        else n = $urandom_range(1, eff_len() + 10);
        add_image(n, $urandom_range(0, 9) < 7, $urandom_range(0, 2) == 0);
      end
      wait_idle();
      phase_count++;
    end

    $display("Scanned %0d bytes of %0d sent over %0d random settings plus directed cases",
             bytes_scanned, items_queued, phase_count);
    $display("Checked %0d match reports and %0d not-found reports", found_total, miss_total);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/mbps_pkg.sv
hw/rtl/mbps_cell.sv
hw/rtl/mbps_regs.sv
hw/rtl/masked_byte_pattern_search.sv
tb/sv/tb.sv
